/* rtl/core/dual_stack_shared_memory_macros.svh */
// assertion macros for the dual stack block
`ifndef DUAL_STACK_SHARED_MEMORY_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_MACROS_SVH

// same-cycle implication
`define DSSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/dssm_pkg.sv */
package dssm_pkg;

	localparam int DEPTH = 16;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = 32;
	localparam int MODE_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FIRST  = 3'd0,
		MODE_PUSH_SECOND = 3'd1,
		MODE_POP_FIRST   = 3'd2,
		MODE_POP_SECOND  = 3'd3,
		MODE_DUMP_FIRST  = 3'd4,
		MODE_DUMP_SECOND = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_DUMP_START,
		OP_DUMP_STEP,
		OP_REJ_FULL,
		OP_REJ_EMPTY,
		OP_NOP
	} op_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	typedef struct packed {
		op_t  op;
		logic second;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty_first;
		logic empty_second;
		logic one_first;
		logic one_second;
		logic dump_end;
	} dp_stat_t;

endpackage

/* rtl/core/dssm_ram.sv */
module dssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

/* rtl/core/dssm_ctrl.sv */
module dssm_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [dssm_pkg::MODE_W-1:0]        mode,
	input  dssm_pkg::dp_stat_t                 stat,
	output logic                               busy,
	output dssm_pkg::ctl_cmd_t                 cmd
);
	import dssm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   one_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign one_sel = cmd.second ? stat.one_second : stat.one_first;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.op == OP_DUMP_START && !one_sel) begin
					state_d = S_DUMP;
				end
			end
			S_DUMP: begin
				if (stat.dump_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		cmd.op = OP_NONE;
		cmd.second = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (mode_t'(mode))
						MODE_PUSH_FIRST: begin
							cmd.op = stat.full ? OP_REJ_FULL : OP_PUSH;
						end
						MODE_PUSH_SECOND: begin
							cmd.op = stat.full ? OP_REJ_FULL : OP_PUSH;
							cmd.second = 1'b1;
						end
						MODE_POP_FIRST: begin
							cmd.op = stat.empty_first ? OP_REJ_EMPTY : OP_POP;
						end
						MODE_POP_SECOND: begin
							cmd.op = stat.empty_second ? OP_REJ_EMPTY : OP_POP;
							cmd.second = 1'b1;
						end
						MODE_DUMP_FIRST: begin
							cmd.op = stat.empty_first ? OP_REJ_EMPTY : OP_DUMP_START;
						end
						MODE_DUMP_SECOND: begin
							cmd.op = stat.empty_second ? OP_REJ_EMPTY : OP_DUMP_START;
							cmd.second = 1'b1;
						end
						default: cmd.op = OP_NOP;
					endcase
				end
			end
			S_DUMP: begin
				busy = 1'b1;
				cmd.op = OP_DUMP_STEP;
			end
			default: busy = 1'b0;
		endcase
	end

endmodule

/* rtl/core/dssm_dp.sv */
module dssm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dssm_pkg::ctl_cmd_t                  cmd,
	input  logic signed [dssm_pkg::DW-1:0]      value,
	output dssm_pkg::dp_stat_t                  stat,
	output logic                                strobe,
	output logic [dssm_pkg::STATUS_W-1:0]       status,
	output logic signed [dssm_pkg::DW-1:0]      data,
	output logic                                last
);
	import dssm_pkg::*;

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [CW-1:0] count_first_q;
	logic [CW-1:0] count_second_q;
	logic [AW-1:0] rd_q;
	logic          dump_sel_q;
	logic          strobe_q;
	status_t       status_q;
	logic          last_q;
	logic          sel_ram_q;

	logic [CW:0]    count_sum;
	logic [CW-1:0]  dump_n;
	logic [CW-1:0]  addr_full;
	logic [AW-1:0]  ram_addr;
	logic           ram_we;
	logic           ram_re;
	logic [DW-1:0]  ram_rdata;
	logic           one_sel;

	assign count_sum = {1'b0, count_first_q} + {1'b0, count_second_q};
	assign dump_n = dump_sel_q ? count_second_q : count_first_q;
	assign one_sel = cmd.second ? stat.one_second : stat.one_first;

	assign stat.full = (count_sum >= {1'b0, DEPTH_C});
	assign stat.empty_first = (count_first_q == '0);
	assign stat.empty_second = (count_second_q == '0);
	assign stat.one_first = (count_first_q == ONE_C);
	assign stat.one_second = (count_second_q == ONE_C);
	assign stat.dump_end = (CW'(rd_q) == dump_n - ONE_C);

	// address for the single ram port
	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		addr_full = '0;
		case (cmd.op)
			OP_PUSH: begin
				ram_we = 1'b1;
				addr_full = cmd.second ? (DEPTH_C - ONE_C - count_second_q) : count_first_q;
			end
			OP_POP: begin
				ram_re = 1'b1;
				addr_full = cmd.second ? (DEPTH_C - count_second_q) : (count_first_q - ONE_C);
			end
			OP_DUMP_START: begin
				ram_re = 1'b1;
				addr_full = cmd.second ? (DEPTH_C - ONE_C) : '0;
			end
			OP_DUMP_STEP: begin
				ram_re = 1'b1;
				addr_full = dump_sel_q ? (DEPTH_C - ONE_C - CW'(rd_q)) : CW'(rd_q);
			end
			default: addr_full = '0;
		endcase
	end

	assign ram_addr = addr_full[AW-1:0];

	dssm_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(value),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_first_q <= '0;
			count_second_q <= '0;
			rd_q <= '0;
			dump_sel_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.op != OP_NONE);
			case (cmd.op)
				OP_PUSH: begin
					if (cmd.second) begin
						count_second_q <= count_second_q + ONE_C;
					end else begin
						count_first_q <= count_first_q + ONE_C;
					end
				end
				OP_POP: begin
					if (cmd.second) begin
						count_second_q <= count_second_q - ONE_C;
					end else begin
						count_first_q <= count_first_q - ONE_C;
					end
				end
				OP_DUMP_START: begin
					rd_q <= AW'(1);
					dump_sel_q <= cmd.second;
				end
				OP_DUMP_STEP: begin
					rd_q <= rd_q + AW'(1);
				end
				default: rd_q <= rd_q;
			endcase
		end
	end

	// result beat fields
	always_ff @(posedge clk) begin
		sel_ram_q <= (cmd.op == OP_POP) || (cmd.op == OP_DUMP_START) ||
			(cmd.op == OP_DUMP_STEP);
		case (cmd.op)
			OP_REJ_FULL: begin
				status_q <= ST_FULL;
				last_q <= 1'b1;
			end
			OP_REJ_EMPTY: begin
				status_q <= ST_EMPTY;
				last_q <= 1'b1;
			end
			OP_DUMP_START: begin
				status_q <= ST_DONE;
				last_q <= one_sel;
			end
			OP_DUMP_STEP: begin
				status_q <= ST_DONE;
				last_q <= stat.dump_end;
			end
			default: begin
				status_q <= ST_DONE;
				last_q <= 1'b1;
			end
		endcase
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign last = last_q;
	assign data = sel_ram_q ? ram_rdata : '0;

endmodule

/* rtl/core/dual_stack_shared_memory.sv */
// channel   handshake               fields
// command   start, busy             mode, value
// result    strobe (no stall)       status, data, last, shared_full, empty_first, empty_second
//
// a result beat appears the cycle after its command is taken; push, pop and rejects
// give one beat and leave busy low, so a command may follow every cycle
// a dump of n entries reads one word a cycle through the single ram port: n beats, with
// busy high while the words after the first are read
// reset clears both stack counts; memory contents are not cleared
// the result side cannot stall: each beat is valid for one cycle only
module dual_stack_shared_memory (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [dssm_pkg::MODE_W-1:0]         mode,
	input  logic signed [dssm_pkg::DW-1:0]      value,
	output logic                                strobe,
	output logic [dssm_pkg::STATUS_W-1:0]       status,
	output logic signed [dssm_pkg::DW-1:0]      data,
	output logic                                last,
	output logic                                shared_full,
	output logic                                empty_first,
	output logic                                empty_second
);
	import dssm_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	dssm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (mode),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	dssm_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.value (value),
		.stat  (stat),
		.strobe(strobe),
		.status(status),
		.data  (data),
		.last  (last)
	);

	assign shared_full = stat.full;
	assign empty_first = stat.empty_first;
	assign empty_second = stat.empty_second;

endmodule

/* rtl/core/dssm_checker.sv */
`include "dual_stack_shared_memory_macros.svh"

module dssm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                strobe,
	input logic [dssm_pkg::STATUS_W-1:0]       status,
	input logic signed [dssm_pkg::DW-1:0]      data,
	input logic                                last,
	input logic                                shared_full,
	input logic                                empty_first,
	input logic                                empty_second
);
	import dssm_pkg::*;

	`DSSM_ASSERT_NEXT(a_accept_beat, start && !busy, strobe, "accepted command gave no beat")
	`DSSM_ASSERT_NEXT(a_dump_beat, busy, strobe, "dump cycle gave no beat")
	`DSSM_ASSERT_NOW(a_dump_not_last, busy && strobe, !last, "last beat while dump continues")
	`DSSM_ASSERT_NOW(a_reject_beat, strobe && (status != ST_DONE), last && (data == '0),
		"reject beat not final or has data")
	`DSSM_ASSERT_NOW(a_full_flags, shared_full, !(empty_first && empty_second),
		"full with both stacks empty")

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.strobe      (strobe),
	.status      (status),
	.data        (data),
	.last        (last),
	.shared_full (shared_full),
	.empty_first (empty_first),
	.empty_second(empty_second)
);
